// ===== hw/rtl/anchor_box_generator_assert.svh =====
// assertion macros for the anchor box generator
`ifndef ANCHOR_BOX_GENERATOR_ASSERT_SVH
`define ANCHOR_BOX_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, sampled on clk_i, off while rst_ni is low
`define ABG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked property, sampled on clk_i, also checked during reset
`define ABG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ABG_ASSERT(lbl, prop, msg)
`define ABG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/abg_pkg.sv =====
// shared types and constants of the anchor box generator
`timescale 1ns / 1ps

package abg_pkg;

  // fixed field widths
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned SIDX_W    = 6;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned OFFS_W    = 8;
  localparam int unsigned INV_W     = 24;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ENTRY_W   = 2 * HALF_W;
  localparam int unsigned POS_W     = ROW_W + OFFS_W;
  localparam int unsigned CENTER_W  = POS_W + STEP_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_X      = 3'd0,
    CFG_STEP_Y      = 3'd1,
    CFG_CELL_OFFSET = 3'd2,
    CFG_INV_WIDTH   = 3'd3,
    CFG_INV_HEIGHT  = 3'd4,
    CFG_SHAPE_COUNT = 3'd5,
    CFG_CLIP_ENABLE = 3'd6
  } cfg_idx_e;

  // input opcodes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // control of one corner datapath
  typedef struct packed {
    logic adv;
    logic sub;
    logic clip;
  } corner_ctrl_t;

endpackage

// ===== hw/rtl/anchor_box_generator.sv =====
// anchor box generator top level: config, sequencer, shape table and box pipeline
// a load beat writes the shape table as it is accepted; a generate beat is accepted, then its
// center is formed, then one table read is issued per shape, and input is refused until
// the walk ends and each box has passed the registered stages read, add, multiply and round
// the four corner units share each table read, so one box leaves per cycle when unstalled
// rst_ni clears control and config registers; the shape table has no reset
`timescale 1ns / 1ps

module anchor_box_generator #(
  parameter int unsigned MAX_SHAPES       = 64,
  parameter int unsigned MAX_FEATURE_SIDE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_row[9:0], cell_col[19:10], shape_index[25:20], half_width[41:26],
  // half_height[57:42], zero[63:58]
  input  logic [63:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // x_min[15:0], y_min[31:16], x_max[47:32], y_max[63:48], prior_index[69:64],
  // zero[71:70]
  output logic [71:0] m_axis_tdata,
  // last_prior
  output logic        m_axis_tlast
);

`include "anchor_box_generator_assert.svh"

  localparam int unsigned IDX_W  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int unsigned SIDE_W = 13;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CENTER = 3'b010,
    ST_RUN    = 3'b100
  } state_e;

  // configuration registers
  logic [abg_pkg::STEP_W-1:0]  step_x_q, step_y_q;
  logic [abg_pkg::OFFS_W-1:0]  cell_offset_q;
  logic [abg_pkg::INV_W-1:0]   inv_w_q, inv_h_q;
  logic [abg_pkg::COUNT_W-1:0] shape_count_q;
  logic                        clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q      <= abg_pkg::STEP_W'(16);
      step_y_q      <= abg_pkg::STEP_W'(16);
      cell_offset_q <= abg_pkg::OFFS_W'(128);
      inv_w_q       <= abg_pkg::INV_W'(65536);
      inv_h_q       <= abg_pkg::INV_W'(65536);
      shape_count_q <= abg_pkg::COUNT_W'(1);
      clip_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        abg_pkg::CFG_STEP_X:      step_x_q      <= cfg_wdata_i[abg_pkg::STEP_W-1:0];
        abg_pkg::CFG_STEP_Y:      step_y_q      <= cfg_wdata_i[abg_pkg::STEP_W-1:0];
        abg_pkg::CFG_CELL_OFFSET: cell_offset_q <= cfg_wdata_i[abg_pkg::OFFS_W-1:0];
        abg_pkg::CFG_INV_WIDTH:   inv_w_q       <= cfg_wdata_i[abg_pkg::INV_W-1:0];
        abg_pkg::CFG_INV_HEIGHT:  inv_h_q       <= cfg_wdata_i[abg_pkg::INV_W-1:0];
        abg_pkg::CFG_SHAPE_COUNT: shape_count_q <= cfg_wdata_i[abg_pkg::COUNT_W-1:0];
        abg_pkg::CFG_CLIP_ENABLE: clip_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [abg_pkg::ROW_W-1:0]  in_row, in_col;
  logic [abg_pkg::SIDX_W-1:0] in_sidx;
  logic [abg_pkg::HALF_W-1:0] in_hw, in_hh;

  assign in_row  = s_axis_tdata[9:0];
  assign in_col  = s_axis_tdata[19:10];
  assign in_sidx = s_axis_tdata[25:20];
  assign in_hw   = s_axis_tdata[41:26];
  assign in_hh   = s_axis_tdata[57:42];

  // effective shape count, saturated to the table size
  logic [abg_pkg::COUNT_W-1:0] count_eff;
  assign count_eff = (shape_count_q > abg_pkg::COUNT_W'(MAX_SHAPES))
                   ? abg_pkg::COUNT_W'(MAX_SHAPES) : shape_count_q;

  // sequencer and pipeline valids
  state_e state_q, state_d;
  logic   v1_q, v2_q, v3_q, out_valid_q;
  logic   adv, s_acc, is_gen, is_load, cell_ok, load_ok, issue, issue_last;
  logic [IDX_W-1:0] k_q, k_d;
  logic [abg_pkg::COUNT_W-1:0] count_q;
  logic [abg_pkg::POS_W-1:0] pos_x_q, pos_y_q;
  logic [abg_pkg::CENTER_W-1:0] cx_q, cy_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !v1_q && !v2_q && !v3_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_gen        = s_acc && (s_axis_tuser == abg_pkg::OP_GENERATE);
  assign is_load       = s_acc && (s_axis_tuser == abg_pkg::OP_LOAD);
  assign cell_ok       = ({3'b000, in_row} < SIDE_W'(MAX_FEATURE_SIDE))
                      && ({3'b000, in_col} < SIDE_W'(MAX_FEATURE_SIDE))
                      && (count_eff != '0);
  assign load_ok       = ({1'b0, in_sidx} < abg_pkg::COUNT_W'(MAX_SHAPES));
  assign issue         = (state_q == ST_RUN) && adv;
  assign issue_last    = (abg_pkg::COUNT_W'(k_q) == count_q - abg_pkg::COUNT_W'(1));

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_gen && cell_ok) begin
          state_d = ST_CENTER;
        end
      end
      ST_CENTER: begin
        k_d     = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (issue) begin
          if (issue_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // cell position and center, latched once per generate beat that passes the cell check
  always_ff @(posedge clk_i) begin
    if (is_gen && cell_ok) begin
      pos_x_q <= {in_col, cell_offset_q};
      pos_y_q <= {in_row, cell_offset_q};
      count_q <= count_eff;
    end
    if (state_q == ST_CENTER) begin
      cx_q <= abg_pkg::CENTER_W'(pos_x_q) * abg_pkg::CENTER_W'(step_x_q);
      cy_q <= abg_pkg::CENTER_W'(pos_y_q) * abg_pkg::CENTER_W'(step_y_q);
    end
  end

  // shape table
  logic [abg_pkg::ENTRY_W-1:0] rdata;

  abg_shape_mem #(
    .DEPTH (MAX_SHAPES),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (is_load && load_ok),
    .waddr_i (in_sidx[IDX_W-1:0]),
    .wdata_i ({in_hh, in_hw}),
    .re_i    (issue),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  // box pipeline: table read, add, multiply, round
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx_out_q;
  logic             last1_q, last2_q, last3_q, last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx1_q     <= k_q;
      last1_q    <= issue_last;
      idx2_q     <= idx1_q;
      last2_q    <= last1_q;
      idx3_q     <= idx2_q;
      last3_q    <= last2_q;
      idx_out_q  <= idx3_q;
      last_out_q <= last3_q;
    end
  end

  abg_pkg::corner_ctrl_t ctrl_min, ctrl_max;
  logic [abg_pkg::COORD_W-1:0] x_min, y_min, x_max, y_max;

  assign ctrl_min = '{adv: adv, sub: 1'b1, clip: clip_q};
  assign ctrl_max = '{adv: adv, sub: 1'b0, clip: clip_q};

  abg_corner u_x_min (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_min),
    .center_i (cx_q),
    .half_i   (rdata[15:0]),
    .inv_i    (inv_w_q),
    .coord_o  (x_min)
  );

  abg_corner u_y_min (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_min),
    .center_i (cy_q),
    .half_i   (rdata[31:16]),
    .inv_i    (inv_h_q),
    .coord_o  (y_min)
  );

  abg_corner u_x_max (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_max),
    .center_i (cx_q),
    .half_i   (rdata[15:0]),
    .inv_i    (inv_w_q),
    .coord_o  (x_max)
  );

  abg_corner u_y_max (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl_max),
    .center_i (cy_q),
    .half_i   (rdata[31:16]),
    .inv_i    (inv_h_q),
    .coord_o  (y_max)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_out_q;
  assign m_axis_tdata  = {2'b00, abg_pkg::SIDX_W'(idx_out_q), y_max, x_max, y_min, x_min};

  // table reads only happen while the sequencer walks the shapes
  `ABG_ASSERT(a_read_in_run, issue |-> (state_q == ST_RUN), "table read outside run")
  // the final shape read ends the walk
  `ABG_ASSERT(a_last_ends_run, (issue && issue_last) |=> (state_q == ST_IDLE), "walk overran")
  // table writes never overlap a walk or reads in flight
  `ABG_ASSERT(a_load_idle, is_load |-> (state_q == ST_IDLE) && !v1_q && !v2_q && !v3_q,
              "table write while boxes in flight")
  // a reset edge leaves the output idle
  `ABG_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

// ===== hw/rtl/abg_shape_mem.sv =====
// shape table: one write port, one registered read port
`timescale 1ns / 1ps

module abg_shape_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [abg_pkg::ENTRY_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [abg_pkg::ENTRY_W-1:0]  rdata_o
);

  logic [abg_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [abg_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/abg_corner.sv =====
// one box corner: center -/+ half, scale by reciprocal size, round and clamp
`timescale 1ns / 1ps

module abg_corner (
  input  logic                          clk_i,
  input  abg_pkg::corner_ctrl_t         ctrl_i,
  input  logic [abg_pkg::CENTER_W-1:0]  center_i,
  input  logic [abg_pkg::HALF_W-1:0]    half_i,
  input  logic [abg_pkg::INV_W-1:0]     inv_i,
  output logic [abg_pkg::COORD_W-1:0]   coord_o
);

  localparam int unsigned DIFF_W = abg_pkg::CENTER_W + 2;
  localparam int unsigned PROD_W = DIFF_W + abg_pkg::INV_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RSH    = 22;
  localparam int unsigned RND_W  = SUM_W - RSH;
  localparam int unsigned HPAD_W = DIFF_W - abg_pkg::HALF_W - 8;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (RSH - 1);
  localparam logic signed [RND_W-1:0] SAT_LO   = -RND_W'(32768);
  localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'(32767);
  localparam logic signed [RND_W-1:0] CLIP_LO  = RND_W'(0);
  localparam logic signed [RND_W-1:0] CLIP_HI  = RND_W'(16384);

  logic signed [DIFF_W-1:0] center_s, half_s, diff_d, diff_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RND_W-1:0]  rnd, lo, hi, clamped;
  logic [abg_pkg::COORD_W-1:0] coord_d, coord_q;

  assign center_s = $signed({2'b00, center_i});
  assign half_s   = $signed({{HPAD_W{1'b0}}, half_i, 8'h00});
  assign diff_d   = ctrl_i.sub ? (center_s - half_s) : (center_s + half_s);

  assign prod_d = PROD_W'(diff_q) * PROD_W'($signed({1'b0, inv_i}));

  // round half up at the Q2.14 lsb
  assign sum = $signed({prod_q[PROD_W-1], prod_q}) + HALF_LSB;
  assign rnd = sum[SUM_W-1:RSH];

  assign lo = ctrl_i.clip ? CLIP_LO : SAT_LO;
  assign hi = ctrl_i.clip ? CLIP_HI : SAT_HI;

  always_comb begin
    clamped = rnd;
    priority if (rnd < lo) begin
      clamped = lo;
    end else if (rnd > hi) begin
      clamped = hi;
    end else begin
      clamped = rnd;
    end
    coord_d = clamped[abg_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      diff_q  <= diff_d;
      prod_q  <= prod_d;
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

// ===== dv/anchor_box_generator_tb.sv =====
// self-checking testbench for the anchor box generator: shape loads, cell generates, box checks
`timescale 1ns / 1ps

module anchor_box_generator_tb;

  localparam int unsigned MAX_SHAPES   = 64;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 3;

  typedef struct {
    logic signed [abg_pkg::COORD_W-1:0] x_min;
    logic signed [abg_pkg::COORD_W-1:0] y_min;
    logic signed [abg_pkg::COORD_W-1:0] x_max;
    logic signed [abg_pkg::COORD_W-1:0] y_max;
    logic [abg_pkg::SIDX_W-1:0]         prior_index;
    logic                               last_prior;
  } box_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = abg_pkg::CFG_STEP_X;
  logic [23:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cell_row, cell_col, shape_index, half_width, half_height, zero fill
  logic [63:0] s_axis_tdata  = '0;
  // opcode
  logic        s_axis_tuser  = abg_pkg::OP_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // x_min, y_min, x_max, y_max, prior_index, zero fill
  logic [71:0] m_axis_tdata;
  // last_prior
  logic        m_axis_tlast;

  // shadow of the block's registers and shape table
  logic [abg_pkg::STEP_W-1:0]  pitch_x    = 16'd16;
  logic [abg_pkg::STEP_W-1:0]  pitch_y    = 16'd16;
  logic [abg_pkg::OFFS_W-1:0]  center_ofs = 8'd128;
  logic [abg_pkg::INV_W-1:0]   scale_x    = 24'd65536;
  logic [abg_pkg::INV_W-1:0]   scale_y    = 24'd65536;
  logic [abg_pkg::COUNT_W-1:0] n_shapes   = 7'd1;
  logic                        clip_on    = 1'b0;
  logic [abg_pkg::ENTRY_W-1:0] shape_mem [MAX_SHAPES];

  box_t        pending_boxes[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          tx_gaps_on     = 1'b1;
  bit          rx_stall_on    = 1'b1;

  anchor_box_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short idle stretches, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // 36 fraction bits -> q2.14, round half up, then clamp
  function automatic logic signed [abg_pkg::COORD_W-1:0] to_norm(longint scaled);
    longint r;
    r = (scaled + 64'sd2097152) >>> 22;
    if (clip_on) begin
      if (r < 0) r = 0;
      if (r > 16384) r = 16384;
    end else begin
      if (r < -32768) r = -32768;
      if (r > 32767) r = 32767;
    end
    return r[abg_pkg::COORD_W-1:0];
  endfunction

  task automatic predict_cell_boxes(logic [abg_pkg::ROW_W-1:0] row,
                                    logic [abg_pkg::ROW_W-1:0] col);
    longint      cx;
    longint      cy;
    longint      hx;
    longint      hy;
    int unsigned boxes;
    box_t        b;
    cx = (longint'(col) * 256 + longint'(center_ofs)) * longint'(pitch_x);
    cy = (longint'(row) * 256 + longint'(center_ofs)) * longint'(pitch_y);
    boxes = (n_shapes > abg_pkg::COUNT_W'(MAX_SHAPES)) ? MAX_SHAPES : 32'(n_shapes);
    for (int unsigned k = 0; k < boxes; k++) begin
      hx = longint'(shape_mem[k][abg_pkg::HALF_W-1:0]) * 256;
      hy = longint'(shape_mem[k][abg_pkg::ENTRY_W-1:abg_pkg::HALF_W]) * 256;
      b.x_min       = to_norm((cx - hx) * longint'(scale_x));
      b.y_min       = to_norm((cy - hy) * longint'(scale_y));
      b.x_max       = to_norm((cx + hx) * longint'(scale_x));
      b.y_max       = to_norm((cy + hy) * longint'(scale_y));
      b.prior_index = abg_pkg::SIDX_W'(k);
      b.last_prior  = (k == boxes - 1);
      pending_boxes.push_back(b);
    end
  endtask

  // must be entered at a rising edge; leaves tvalid high after the accepting edge
  task automatic send_beat(logic op, logic [abg_pkg::ROW_W-1:0] row,
                           logic [abg_pkg::ROW_W-1:0] col,
                           logic [abg_pkg::SIDX_W-1:0] sidx, logic [abg_pkg::HALF_W-1:0] hw,
                           logic [abg_pkg::HALF_W-1:0] hh);
    int unsigned gap;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, hh, hw, sidx, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == abg_pkg::OP_LOAD) begin
      shape_mem[sidx] = {hh, hw};
    end else begin
      predict_cell_boxes(row, col);
    end
  endtask

  task automatic load_shape(logic [abg_pkg::SIDX_W-1:0] sidx, logic [abg_pkg::HALF_W-1:0] hw,
                            logic [abg_pkg::HALF_W-1:0] hh);
    send_beat(abg_pkg::OP_LOAD, '0, '0, sidx, hw, hh);
  endtask

  task automatic gen_cell(logic [abg_pkg::ROW_W-1:0] row, logic [abg_pkg::ROW_W-1:0] col);
    send_beat(abg_pkg::OP_GENERATE, row, col, '0, '0, '0);
  endtask

  // wait for every box, then for a trailing load or empty generate to retire
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(abg_pkg::cfg_idx_e idx, logic [abg_pkg::CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    unique case (idx)
      abg_pkg::CFG_STEP_X:      pitch_x    = value[abg_pkg::STEP_W-1:0];
      abg_pkg::CFG_STEP_Y:      pitch_y    = value[abg_pkg::STEP_W-1:0];
      abg_pkg::CFG_CELL_OFFSET: center_ofs = value[abg_pkg::OFFS_W-1:0];
      abg_pkg::CFG_INV_WIDTH:   scale_x    = value[abg_pkg::INV_W-1:0];
      abg_pkg::CFG_INV_HEIGHT:  scale_y    = value[abg_pkg::INV_W-1:0];
      abg_pkg::CFG_SHAPE_COUNT: n_shapes   = value[abg_pkg::COUNT_W-1:0];
      abg_pkg::CFG_CLIP_ENABLE: clip_on    = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [abg_pkg::ROW_W-1:0] rand_cell_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return abg_pkg::ROW_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [abg_pkg::HALF_W-1:0] rand_half();
    return ($urandom_range(0, 1) == 0) ? abg_pkg::HALF_W'($urandom_range(0, 16'h1000))
                                       : abg_pkg::HALF_W'($urandom_range(0, 65535));
  endfunction

  // mode 1 takes the low end of each range, mode 2 the high end
  function automatic logic [abg_pkg::CFG_DW-1:0] pick_setting(int mode, int unsigned lo,
                                                              int unsigned hi,
                                                              int unsigned typical);
    unique case (mode)
      1:       return abg_pkg::CFG_DW'(lo);
      2:       return abg_pkg::CFG_DW'(hi);
      default: return ($urandom_range(0, 3) == 0) ? abg_pkg::CFG_DW'($urandom_range(lo, hi))
                                                  : abg_pkg::CFG_DW'(typical);
    endcase
  endfunction

  task automatic test_reset_config();
    load_shape(6'd0, 16'h0100, 16'h0080);
    gen_cell(10'd0, 10'd0);
    gen_cell(10'd1023, 10'd1023);
    gen_cell(10'd7, 10'd3);
  endtask

  task automatic test_field_extremes();
    load_shape(6'd1, 16'hFFFF, 16'hFFFF);
    load_shape(6'd2, 16'h0000, 16'h0000);
    load_shape(6'd3, 16'hFFFF, 16'h0000);
    load_shape(6'd63, 16'h0000, 16'hFFFF);
    quiesce();
    write_reg(abg_pkg::CFG_SHAPE_COUNT, 24'd4);
    gen_cell(10'd0, 10'd1023);
    gen_cell(10'd1023, 10'd0);
    gen_cell(10'd1023, 10'd1023);
  endtask

  task automatic test_clip_and_saturation();
    quiesce();
    write_reg(abg_pkg::CFG_CLIP_ENABLE, 24'd1);
    gen_cell(10'd0, 10'd0);
    quiesce();
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'h0FFFFF);
    write_reg(abg_pkg::CFG_INV_HEIGHT, 24'h0FFFFF);
    gen_cell(10'd512, 10'd300);
    quiesce();
    write_reg(abg_pkg::CFG_CLIP_ENABLE, 24'd0);
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'hFFFFFF);
    write_reg(abg_pkg::CFG_INV_HEIGHT, 24'hFFFFFF);
    gen_cell(10'd1023, 10'd1023);
    gen_cell(10'd0, 10'd0);
  endtask

  // zero pitch and zero scale are used as given; offset at both ends
  task automatic test_zero_scale_and_offset();
    quiesce();
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'd65536);
    write_reg(abg_pkg::CFG_INV_HEIGHT, 24'd65536);
    write_reg(abg_pkg::CFG_STEP_X, 24'd0);
    write_reg(abg_pkg::CFG_STEP_Y, 24'd0);
    gen_cell(10'd700, 10'd800);
    quiesce();
    write_reg(abg_pkg::CFG_STEP_X, 24'd1);
    write_reg(abg_pkg::CFG_STEP_Y, 24'd65535);
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'd0);
    gen_cell(10'd5, 10'd5);
    quiesce();
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'd1);
    write_reg(abg_pkg::CFG_INV_HEIGHT, 24'd43690);
    write_reg(abg_pkg::CFG_CELL_OFFSET, 24'd0);
    gen_cell(10'd20, 10'd1000);
    quiesce();
    write_reg(abg_pkg::CFG_CELL_OFFSET, 24'd255);
    gen_cell(10'd1000, 10'd20);
  endtask

  task automatic test_shape_count_edges();
    quiesce();
    write_reg(abg_pkg::CFG_SHAPE_COUNT, 24'd0);
    gen_cell(10'd3, 10'd4);
    quiesce();
    write_reg(abg_pkg::CFG_SHAPE_COUNT, 24'd1);
    gen_cell(10'd4, 10'd3);
  endtask

  // fill every entry, then run the full count and a count above the table size
  task automatic test_full_table();
    for (int k = 0; k < MAX_SHAPES; k++) begin
      load_shape(abg_pkg::SIDX_W'(k), rand_half(), rand_half());
    end
    quiesce();
    write_reg(abg_pkg::CFG_STEP_X, 24'd256);
    write_reg(abg_pkg::CFG_STEP_Y, 24'd128);
    write_reg(abg_pkg::CFG_CELL_OFFSET, 24'd128);
    write_reg(abg_pkg::CFG_INV_WIDTH, 24'd55924);
    write_reg(abg_pkg::CFG_INV_HEIGHT, 24'd55924);
    write_reg(abg_pkg::CFG_SHAPE_COUNT, 24'd64);
    gen_cell(rand_cell_index(), rand_cell_index());
    quiesce();
    write_reg(abg_pkg::CFG_SHAPE_COUNT, 24'd127);
    write_reg(abg_pkg::CFG_CLIP_ENABLE, 24'd1);
    gen_cell(rand_cell_index(), rand_cell_index());
  endtask

  task automatic test_random_traffic();
    int mode;
    for (int p = 0; p < PHASES; p++) begin
      mode = (p == 1 || p == 2) ? p : 0;
      quiesce();
      // first phase runs back to back on both sides
      tx_gaps_on  = (p != 0);
      rx_stall_on = (p != 0);
      write_reg(abg_pkg::CFG_STEP_X,
                pick_setting(mode, 1, 65535, $urandom_range(64, 1024)));
      write_reg(abg_pkg::CFG_STEP_Y,
                pick_setting(mode, 1, 65535, $urandom_range(64, 1024)));
      write_reg(abg_pkg::CFG_CELL_OFFSET,
                pick_setting(mode, 0, 255, $urandom_range(0, 255)));
      write_reg(abg_pkg::CFG_INV_WIDTH,
                pick_setting(mode, 1, 16777215, $urandom_range(8000, 120000)));
      write_reg(abg_pkg::CFG_INV_HEIGHT,
                pick_setting(mode, 1, 16777215, $urandom_range(8000, 120000)));
      write_reg(abg_pkg::CFG_SHAPE_COUNT,
                pick_setting(mode, 1, 64, $urandom_range(1, 8)));
      write_reg(abg_pkg::CFG_CLIP_ENABLE,
                pick_setting(mode, 0, 1, $urandom_range(0, 1)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 70) begin
          gen_cell(rand_cell_index(), rand_cell_index());
        end else begin
          load_shape(abg_pkg::SIDX_W'($urandom_range(0, 63)), rand_half(), rand_half());
        end
      end
    end
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    box_t got;
    box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x_min       = m_axis_tdata[15:0];
      got.y_min       = m_axis_tdata[31:16];
      got.x_max       = m_axis_tdata[47:32];
      got.y_max       = m_axis_tdata[63:48];
      got.prior_index = m_axis_tdata[69:64];
      got.last_prior  = m_axis_tlast;
      if (pending_boxes.size() == 0) begin
        $error("box beat with nothing expected: prior_index %0d", got.prior_index);
        mismatch_count++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("x_min", want.x_min, got.x_min);
        check_field("y_min", want.y_min, got.y_min);
        check_field("x_max", want.x_max, got.x_max);
        check_field("y_max", want.y_max, got.y_max);
        check_field("prior_index", want.prior_index, got.prior_index);
        check_field("last_prior", want.last_prior, got.last_prior);
      end
    end
  end

  // ends a hung run: no beat on either side and no config write for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no progress for %0d cycles, %0d boxes outstanding", QUIET_LIMIT,
             pending_boxes.size());
      $display("** anchor_box_generator: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_config();
    test_field_extremes();
    test_clip_and_saturation();
    test_zero_scale_and_offset();
    test_shape_count_edges();
    test_full_table();
    test_random_traffic();
    quiesce();
    if (mismatch_count == 0) begin
      $display("** anchor_box_generator: PASSED **");
    end else begin
      $display("** anchor_box_generator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== anchor_box_generator.f =====
+incdir+hw/rtl
hw/rtl/abg_pkg.sv
hw/rtl/abg_shape_mem.sv
hw/rtl/abg_corner.sv
hw/rtl/anchor_box_generator.sv
dv/anchor_box_generator_tb.sv
